// File: sv/pdrc_pkg.sv
// Shared types, constants and helpers for the pixel depth/range converter.
package pdrc_pkg;

  localparam int SAMPLE_W                 = 16;
  localparam int BITS_W                   = 5;
  localparam int CFG_INDEX_W              = 3;
  localparam int CFG_DATA_W               = 5;
  localparam int DEF_MAX_SAMPLE_BITS      = 16;
  localparam int DEF_FACTOR_FRACTION_BITS = 31;
  localparam int FACTOR_INT_BITS          = 9;
  localparam int MIN_BITS                 = 8;
  localparam int CHROMA_LIMITED_SPAN      = 112;
  localparam int LUMA_LIMITED_SPAN        = 219;
  localparam int LUMA_LIMITED_BLACK       = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_BITS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_BITS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IS_CHROMA   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_SOURCE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_TARGET = 3'd4;

  typedef struct packed {
    logic [BITS_W-1:0] source_bits;
    logic [BITS_W-1:0] target_bits;
    logic              is_chroma;
    logic              full_source;
    logic              full_target;
  } cfg_regs_t;

  // Per-configuration constants used by the sample pipeline.
  typedef struct packed {
    logic [BITS_W-1:0]   sb;
    logic [BITS_W-1:0]   tb;
    logic                shift_mode;
    logic [SAMPLE_W-1:0] sofs;
    logic [SAMPLE_W-1:0] dofs;
    logic [SAMPLE_W-1:0] tmax;
    logic                lo;
  } cfg_derived_t;

  localparam cfg_regs_t CFG_RESET = '{
    source_bits: 5'd8, target_bits: 5'd8,
    is_chroma: 1'b0, full_source: 1'b0, full_target: 1'b0
  };

  localparam cfg_derived_t DERIVED_RESET = '{
    sb: 5'd8, tb: 5'd8, shift_mode: 1'b1,
    sofs: 16'd16, dofs: 16'd16, tmax: 16'd255, lo: 1'b0
  };

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_LOAD,
    FS_DIV
  } factor_state_t;

  function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b,
                                                   input logic [BITS_W-1:0] max_b);
    logic [BITS_W-1:0] r;
    if (b < BITS_W'(MIN_BITS)) r = BITS_W'(MIN_BITS);
    else if (b > max_b)        r = max_b;
    else                       r = b;
    return r;
  endfunction

endpackage

// File: sv/pixel_depth_range_convert_core.sv
// Top level of the pixel bit-depth and full/limited range converter.
// Throughput: one sample per cycle while no config write is pending or running;
// back pressure stalls only the full stages, without loss. A config write keeps
// the factor unit busy through its load state (limited to limited) or through the
// load and divider steps; no input or config transaction is taken meanwhile.
// Reset (rst, synchronous): 8-bit limited luma in and out, scale factor 0.
module pixel_depth_range_convert_core import pdrc_pkg::*; #(
  parameter int MAX_SAMPLE_BITS      = DEF_MAX_SAMPLE_BITS,
  parameter int FACTOR_FRACTION_BITS = DEF_FACTOR_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_W-1:0]    sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_W-1:0]    sample_out
);

  localparam int FACTOR_W = FACTOR_INT_BITS + FACTOR_FRACTION_BITS;

  cfg_regs_t           cfg;
  cfg_derived_t        derived, derived_next;
  logic                cfg_we;
  logic                factor_busy;
  logic [FACTOR_W-1:0] factor;
  logic                pipe_valid, pipe_ready;
  logic [BITS_W-1:0]   sb, tb;

  // Config transactions are held off while the divider is running.
  assign cfg_ready = !factor_busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Samples enter only while the scale factor is settled and no write is pending.
  assign pipe_valid = in_valid && !factor_busy && !cfg_valid;
  assign in_ready   = pipe_ready && !factor_busy && !cfg_valid;

  // Register file; an unknown index completes the transaction and writes nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_BITS: cfg.source_bits <= cfg_data[BITS_W-1:0];
        REG_TARGET_BITS: cfg.target_bits <= cfg_data[BITS_W-1:0];
        REG_IS_CHROMA:   cfg.is_chroma   <= cfg_data[0];
        REG_FULL_SOURCE: cfg.full_source <= cfg_data[0];
        REG_FULL_TARGET: cfg.full_target <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-configuration constants: clamped depths, offsets, output bounds.
  // They are registered and settle no later than the factor unit goes idle.
  always_comb begin
    sb = clamp_bits(cfg.source_bits, BITS_W'(MAX_SAMPLE_BITS));
    tb = clamp_bits(cfg.target_bits, BITS_W'(MAX_SAMPLE_BITS));
    derived_next.sb         = sb;
    derived_next.tb         = tb;
    derived_next.shift_mode = !cfg.full_source && !cfg.full_target;
    derived_next.tmax       = SAMPLE_W'(({{SAMPLE_W{1'b0}}, 1'b1} << tb) - (SAMPLE_W+1)'(1));
    derived_next.lo         = cfg.is_chroma && cfg.full_target;
    if (cfg.is_chroma) begin
      // chroma is centered at half scale on both sides
      derived_next.sofs = SAMPLE_W'({{SAMPLE_W{1'b0}}, 1'b1} << (sb - 5'd1));
      derived_next.dofs = SAMPLE_W'({{SAMPLE_W{1'b0}}, 1'b1} << (tb - 5'd1));
    end else begin
      // limited luma black level scales with depth; full luma starts at zero
      derived_next.sofs = cfg.full_source ? '0 :
                          SAMPLE_W'(LUMA_LIMITED_BLACK) << (sb - BITS_W'(MIN_BITS));
      derived_next.dofs = cfg.full_target ? '0 :
                          SAMPLE_W'(LUMA_LIMITED_BLACK) << (tb - BITS_W'(MIN_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) derived <= DERIVED_RESET;
    else     derived <= derived_next;
  end

  pdrc_factor_unit #(
    .MAX_BITS  (MAX_SAMPLE_BITS),
    .FRAC_BITS (FACTOR_FRACTION_BITS)
  ) u_factor (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_we),
    .cfg    (cfg),
    .busy   (factor_busy),
    .factor (factor)
  );

  pdrc_pipe #(
    .FRAC_BITS (FACTOR_FRACTION_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pipe_valid),
    .in_ready   (pipe_ready),
    .sample_in  (sample_in),
    .derived    (derived),
    .factor     (factor),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule

// File: sv/pdrc_factor_unit.sv
// Scale factor computation: num/den rounded half up by a radix-2 restoring divider.
module pdrc_factor_unit import pdrc_pkg::*; #(
  parameter int MAX_BITS  = DEF_MAX_SAMPLE_BITS,
  parameter int FRAC_BITS = DEF_FACTOR_FRACTION_BITS,
  localparam int FACTOR_W = FACTOR_INT_BITS + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cfg_regs_t           cfg,
  output logic                busy,
  output logic [FACTOR_W-1:0] factor
);

  localparam int DIV_W = MAX_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);

  factor_state_t state, state_next;

  logic [MAX_BITS-1:0] rem;
  logic [DIV_W-1:0]    acc;
  logic [CNT_W-1:0]    cnt;

  logic [BITS_W-1:0]   sb, tb;
  logic [MAX_BITS:0]   one_w;
  logic [MAX_BITS:0]   s_full, t_full, s_lim, t_lim;
  logic [MAX_BITS-1:0] num, den;
  logic                shift_mode;
  logic [MAX_BITS:0]   rem_sh;
  logic                ge;
  logic [MAX_BITS-1:0] rem_step;
  logic [DIV_W-1:0]    acc_step;
  logic                last_step;

  // numerator / denominator of the ratio for the current mode
  always_comb begin
    sb         = clamp_bits(cfg.source_bits, BITS_W'(MAX_BITS));
    tb         = clamp_bits(cfg.target_bits, BITS_W'(MAX_BITS));
    one_w      = (MAX_BITS+1)'(1);
    shift_mode = !cfg.full_source && !cfg.full_target;
    if (cfg.is_chroma) begin
      s_full = (one_w << (sb - 5'd1)) - one_w;
      t_full = (one_w << (tb - 5'd1)) - one_w;
      s_lim  = (MAX_BITS+1)'(CHROMA_LIMITED_SPAN) << (sb - BITS_W'(MIN_BITS));
      t_lim  = (MAX_BITS+1)'(CHROMA_LIMITED_SPAN) << (tb - BITS_W'(MIN_BITS));
    end else begin
      s_full = (one_w << sb) - one_w;
      t_full = (one_w << tb) - one_w;
      s_lim  = (MAX_BITS+1)'(LUMA_LIMITED_SPAN) << (sb - BITS_W'(MIN_BITS));
      t_lim  = (MAX_BITS+1)'(LUMA_LIMITED_SPAN) << (tb - BITS_W'(MIN_BITS));
    end
    num = cfg.full_target ? MAX_BITS'(t_full) : MAX_BITS'(t_lim);
    den = cfg.full_source ? MAX_BITS'(s_full) : MAX_BITS'(s_lim);
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh    = {rem, acc[DIV_W-1]};
    ge        = rem_sh >= {1'b0, den};
    rem_step  = ge ? MAX_BITS'(rem_sh - {1'b0, den}) : MAX_BITS'(rem_sh);
    acc_step  = {acc[DIV_W-2:0], ge};
    last_step = (cnt == CNT_W'(1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FS_IDLE: if (start) state_next = FS_LOAD;
      FS_LOAD: state_next = shift_mode ? FS_IDLE : FS_DIV;
      FS_DIV:  if (last_step) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    unique case (state)
      FS_IDLE: busy = 1'b0;
      FS_LOAD: busy = 1'b1;
      FS_DIV:  busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= FS_IDLE;
      factor <= '0;
    end else begin
      state <= state_next;
      if (state == FS_LOAD && shift_mode) factor <= '0;
      if (state == FS_DIV && last_step)   factor <= FACTOR_W'(acc_step);
    end
  end

  always_ff @(posedge clk) begin
    if (state == FS_LOAD) begin
      rem <= '0;
      acc <= {num, FRAC_BITS'(den >> 1)};
      cnt <= CNT_W'(DIV_W);
    end else if (state == FS_DIV) begin
      rem <= rem_step;
      acc <= acc_step;
      cnt <= cnt - CNT_W'(1);
    end
  end

  a_div_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == FS_DIV) |-> (cnt != '0))
    else $error("divider running with exhausted count");

  a_factor_held: assert property (@(posedge clk) disable iff (rst)
    (state == FS_IDLE && !start) |=> $stable(factor))
    else $error("scale factor changed while idle");

endmodule

// File: sv/pdrc_pipe.sv
// Five-stage sample pipeline: offset, split multiply, accumulate, rescale, clamp.
module pdrc_pipe import pdrc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FACTOR_FRACTION_BITS,
  localparam int FACTOR_W = FACTOR_INT_BITS + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  cfg_derived_t        derived,
  input  logic [FACTOR_W-1:0] factor,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SAMPLE_W-1:0] sample_out
);

  localparam int LO_W   = (FACTOR_W + 1) / 2;
  localparam int HI_W   = FACTOR_W - LO_W;
  localparam int PROD_W = SAMPLE_W + FACTOR_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q_W    = SUM_W - FRAC_BITS;

  logic valid1, valid2, valid3, valid4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;

  logic [SAMPLE_W-1:0]      mag1, ysh1, ysh2, ysh3, ysh4;
  logic                     neg1, neg2, neg3;
  logic [SAMPLE_W+LO_W-1:0] pl2;
  logic [SAMPLE_W+HI_W-1:0] ph2;
  logic [PROD_W-1:0]        prod3;
  logic [Q_W-1:0]           q4;

  logic [SAMPLE_W:0]   diff, rnd, t_rnd;
  logic [SAMPLE_W-1:0] mag_in, sat, y_shift;
  logic [BITS_W-1:0]   sh_dn;
  logic [SUM_W-1:0]    off, prod_w, total;
  logic [Q_W-1:0]      tmax_w, lo_w, q_clamped;

  assign rdy_out  = !out_valid || out_ready;
  assign rdy4     = !valid4 || rdy_out;
  assign rdy3     = !valid3 || rdy4;
  assign rdy2     = !valid2 || rdy3;
  assign rdy1     = !valid1 || rdy2;
  assign in_ready = rdy1;

  // stage 1 logic: offset removal and the plain shift path
  always_comb begin
    diff   = {1'b0, sample_in} - {1'b0, derived.sofs};
    mag_in = diff[SAMPLE_W] ? (derived.sofs - sample_in) : diff[SAMPLE_W-1:0];
    sh_dn  = derived.sb - derived.tb;
    rnd    = (SAMPLE_W+1)'(1) << (sh_dn - 5'd1);
    t_rnd  = {1'b0, sample_in} + rnd;
    sat    = t_rnd[SAMPLE_W] ? {SAMPLE_W{1'b1}} : t_rnd[SAMPLE_W-1:0];
    if (derived.tb > derived.sb)      y_shift = sample_in << (derived.tb - derived.sb);
    else if (derived.sb > derived.tb) y_shift = sat >> sh_dn;
    else                              y_shift = sample_in;
  end

  // stage 4 logic: add target offset plus half, floor, negative totals give zero
  always_comb begin
    off    = SUM_W'({derived.dofs, 1'b1, {(FRAC_BITS-1){1'b0}}});
    prod_w = SUM_W'(prod3);
    if (!neg3)               total = off + prod_w;
    else if (prod_w >= off)  total = '0;
    else                     total = off - prod_w;
  end

  // stage 5 logic: clamp to [lo, tmax]
  always_comb begin
    tmax_w = Q_W'(derived.tmax);
    lo_w   = Q_W'(derived.lo);
    if (q4 > tmax_w)    q_clamped = tmax_w;
    else if (q4 < lo_w) q_clamped = lo_w;
    else                q_clamped = q4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      valid4    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    valid1    <= in_valid;
      if (rdy2)    valid2    <= valid1;
      if (rdy3)    valid3    <= valid2;
      if (rdy4)    valid4    <= valid3;
      if (rdy_out) out_valid <= valid4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      mag1 <= mag_in;
      neg1 <= diff[SAMPLE_W];
      ysh1 <= y_shift;
    end
    if (rdy2 && valid1) begin
      pl2  <= mag1 * factor[LO_W-1:0];
      ph2  <= mag1 * factor[FACTOR_W-1:LO_W];
      neg2 <= neg1;
      ysh2 <= ysh1;
    end
    if (rdy3 && valid2) begin
      prod3 <= (PROD_W'(ph2) << LO_W) + PROD_W'(pl2);
      neg3  <= neg2;
      ysh3  <= ysh2;
    end
    if (rdy4 && valid3) begin
      q4   <= total[SUM_W-1:FRAC_BITS];
      ysh4 <= ysh3;
    end
    if (rdy_out && valid4) begin
      sample_out <= derived.shift_mode ? ysh4 : SAMPLE_W'(q_clamped);
    end
  end

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    (valid4 && !rdy4) |=> (valid4 && $stable(q4) && $stable(ysh4)))
    else $error("stalled stage 4 lost its transaction");

  a_backpressure_full: assert property (@(posedge clk) disable iff (rst)
    (valid2 && !rdy2) |-> (valid3 && valid4 && out_valid && !out_ready))
    else $error("stage 2 stalled with a free slot downstream");

endmodule

// File: bench/tb.sv
// Self-checking testbench for the pixel depth and range converter core.
module tb;
  import pdrc_pkg::*;

  localparam int MAX_BITS    = DEF_MAX_SAMPLE_BITS;
  localparam int FRAC        = DEF_FACTOR_FRACTION_BITS;
  localparam int TOTAL_ITEMS = 900;   // directed plus random samples
  localparam int HOLD_CYCLES = 150;   // long output stall, fills the pipe
  localparam int TAIL_CYCLES = 20;    // quiet time after the last result
  // Slowest legal run: ~900 samples, ~20 settings of 5 writes each and
  // one long stall; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  // Indexes that decode to no register; writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // Scoreboard: mirrors the register file and the scale factor, predicts
  // each converted sample and checks results in order.
  class sample_scoreboard;
    cfg_regs_t           regs;
    logic [63:0]         factor;
    logic [SAMPLE_W-1:0] expected_samples[$];
    int                  mismatches;
    int                  checked;

    function new();
      regs       = CFG_RESET;
      mismatches = 0;
      checked    = 0;
      update_factor();
    endfunction

    // Depth registers outside 8..MAX act as the nearest bound.
    function logic [BITS_W-1:0] effective_depth(input logic [BITS_W-1:0] b);
      if (b < BITS_W'(MIN_BITS)) return BITS_W'(MIN_BITS);
      if (b > BITS_W'(MAX_BITS)) return BITS_W'(MAX_BITS);
      return b;
    endfunction

    function int depth_full_scale();
      return (1 << effective_depth(regs.source_bits)) - 1;
    endfunction

    // Ratio of target span to source span, rounded half up, FRAC fraction bits.
    function void update_factor();
      logic [BITS_W-1:0] s, t;
      logic [63:0]       num, den;
      s = effective_depth(regs.source_bits);
      t = effective_depth(regs.target_bits);
      if (!regs.full_source && !regs.full_target) begin
        factor = '0;
        return;
      end
      if (regs.is_chroma) begin
        if (regs.full_source && regs.full_target) begin
          num = (64'd1 << (t - 1)) - 64'd1;
          den = (64'd1 << (s - 1)) - 64'd1;
        end else if (regs.full_target) begin
          num = (64'd1 << (t - 1)) - 64'd1;
          den = 64'(CHROMA_LIMITED_SPAN) << (s - 8);
        end else begin
          num = 64'(CHROMA_LIMITED_SPAN) << (t - 8);
          den = (64'd1 << (s - 1)) - 64'd1;
        end
      end else begin
        if (regs.full_source && regs.full_target) begin
          num = (64'd1 << t) - 64'd1;
          den = (64'd1 << s) - 64'd1;
        end else if (regs.full_target) begin
          num = (64'd1 << t) - 64'd1;
          den = 64'(LUMA_LIMITED_SPAN) << (s - 8);
        end else begin
          num = 64'(LUMA_LIMITED_SPAN) << (t - 8);
          den = (64'd1 << s) - 64'd1;
        end
      end
      factor = ((num << FRAC) + den / 64'd2) / den;
    endfunction

    function void set_reg(input logic [CFG_INDEX_W-1:0] index,
                          input logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_SOURCE_BITS: regs.source_bits = data;
        REG_TARGET_BITS: regs.target_bits = data;
        REG_IS_CHROMA:   regs.is_chroma   = data[0];
        REG_FULL_SOURCE: regs.full_source = data[0];
        REG_FULL_TARGET: regs.full_target = data[0];
        default:         return;
      endcase
      update_factor();
    endfunction

    function logic [SAMPLE_W-1:0] convert_sample(input logic [SAMPLE_W-1:0] x);
      logic [BITS_W-1:0] s, t;
      logic [31:0]       w;
      logic [95:0]       xw, sofs, dofs, off, p, q, tmax, lo;
      s  = effective_depth(regs.source_bits);
      t  = effective_depth(regs.target_bits);
      xw = {80'd0, x};
      if (!regs.full_source && !regs.full_target) begin
        // limited on both sides: plain shift, rounded and saturated on reduce
        if (t > s) begin
          w = {16'd0, x} << (t - s);
        end else if (s > t) begin
          w = {16'd0, x} + (32'd1 << (s - t - 1));
          if (w > 32'hFFFF) w = 32'hFFFF;
          w = w >> (s - t);
        end else begin
          w = {16'd0, x};
        end
        return w[SAMPLE_W-1:0];
      end
      tmax = (96'd1 << t) - 96'd1;
      lo   = (regs.is_chroma && regs.full_target) ? 96'd1 : 96'd0;
      if (regs.is_chroma) begin
        sofs = 96'd1 << (s - 1);
        dofs = 96'd1 << (t - 1);
      end else begin
        sofs = regs.full_source ? 96'd0 : 96'(LUMA_LIMITED_BLACK) << (s - 8);
        dofs = regs.full_target ? 96'd0 : 96'(LUMA_LIMITED_BLACK) << (t - 8);
      end
      off = (dofs << FRAC) + (96'd1 << (FRAC - 1));
      if (xw >= sofs) begin
        q = ((xw - sofs) * factor + off) >> FRAC;
      end else begin
        p = (sofs - xw) * factor;
        q = (p >= off) ? 96'd0 : (off - p) >> FRAC;
      end
      if (q < lo) q = lo;
      if (q > tmax) q = tmax;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_input(input logic [SAMPLE_W-1:0] x);
      expected_samples.push_back(convert_sample(x));
    endfunction

    function void check_result(input logic [SAMPLE_W-1:0] y);
      logic [SAMPLE_W-1:0] e;
      if (expected_samples.size() == 0) begin
        $error("sample_out: unexpected transaction, expected none, actual %0d", y);
        mismatches++;
        return;
      end
      e = expected_samples.pop_front();
      checked++;
      if (y !== e) begin
        $error("sample_out mismatch: expected %0d, actual %0d", e, y);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    sample_in;
  logic                   out_valid;
  logic                   out_ready;
  logic [SAMPLE_W-1:0]    sample_out;

  bit hold_request = 1'b0;  // main asks the receiver for one long stall
  bit no_idle      = 1'b0;  // back-to-back stretch on both sides
  int sent_count   = 0;
  int setting_count = 0;
  int cycle_count  = 0;

  sample_scoreboard board = new();

  pixel_depth_range_convert_core #(
    .MAX_SAMPLE_BITS      (MAX_BITS),
    .FACTOR_FRACTION_BITS (FRAC)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, board.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Monitor: every transaction is seen at the rising edge, before the
  // design's registers update, so sampling is free of races.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)   board.note_input(sample_in);
      if (out_valid && out_ready) board.check_result(sample_out);
    end
  end

  // Receiver: a random stall before each result, none in the
  // back-to-back stretches, and one long stall on request while the sender
  // keeps pushing, so the pipe fills and in_ready drops.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      repeat (stall) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offer one sample after a random gap; returns at the falling edge after
  // acceptance with in_valid still high, so a zero gap keeps it asserted.
  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    sample_in = x;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
  endtask

  // One register write; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Wait for the pipe to empty, then write all five registers. Flag
  // registers get random upper data bits, which the block must ignore.
  task automatic apply_setting(input logic [BITS_W-1:0] s, t,
                               input bit c, fs, ft);
    in_valid = 1'b0;
    drain_results();
    write_reg(REG_SOURCE_BITS, s);
    write_reg(REG_TARGET_BITS, t);
    write_reg(REG_IS_CHROMA,   {4'($urandom_range(0, 15)), c});
    write_reg(REG_FULL_SOURCE, {4'($urandom_range(0, 15)), fs});
    write_reg(REG_FULL_TARGET, {4'($urandom_range(0, 15)), ft});
    cfg_valid = 1'b0;
    setting_count++;
  endtask

  // Mostly legal depths, sometimes any 5-bit value to hit the clamp.
  function automatic logic [BITS_W-1:0] rand_depth();
    if ($urandom_range(0, 6) == 0) return BITS_W'($urandom_range(0, 31));
    return BITS_W'($urandom_range(MIN_BITS, MAX_BITS));
  endfunction

  initial begin : stimulus
    int                  phase;
    int                  count;
    int                  lim;
    logic [SAMPLE_W-1:0] x;

    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Reset setting, 8-bit limited luma both sides: equal depths pass
    // through, even a sample far above the source depth.
    send_sample(16'd0);
    send_sample(16'd255);
    send_sample(16'hFFFF);
    send_sample(16'h5A5A);

    // Limited expand 8 -> 16: left shift, only the low 16 bits survive.
    apply_setting(5'd8, 5'd16, 1'b0, 1'b0, 1'b0);
    send_sample(16'd255);
    send_sample(16'hFFFF);

    // Limited reduce 16 -> 8: half-LSB round saturates at full scale.
    apply_setting(5'd16, 5'd8, 1'b0, 1'b0, 1'b0);
    send_sample(16'hFFFF);
    send_sample(16'h7F7F);
    send_sample(16'd0);

    // Full luma 8 -> 16: exact x * 257.
    apply_setting(5'd8, 5'd16, 1'b0, 1'b1, 1'b1);
    send_sample(16'd0);
    send_sample(16'd255);
    send_sample(16'd128);

    // Limited chroma 10 -> full 8: far below the centre clamps to 1.
    apply_setting(5'd10, 5'd8, 1'b1, 1'b0, 1'b1);
    send_sample(16'd0);
    send_sample(16'd1023);
    send_sample(16'd512);

    // Limited luma -> full, 8 bits: below black clamps to 0, top clamps.
    apply_setting(5'd8, 5'd8, 1'b0, 1'b0, 1'b1);
    send_sample(16'd0);
    send_sample(16'd235);
    send_sample(16'hFFFF);

    // Depths out of range (0 acts as 8, 31 as 16), full chroma -> limited.
    apply_setting(5'd0, 5'd31, 1'b1, 1'b1, 1'b0);
    send_sample(16'd128);
    send_sample(16'hFFFF);
    send_sample(16'd0);

    // Depths just outside the range, limited shift path; then writes to
    // undecoded indexes, which must leave the setting alone.
    apply_setting(5'd7, 5'd17, 1'b0, 1'b0, 1'b0);
    write_reg(REG_SPARE_LO, 5'($urandom_range(0, 31)));
    write_reg(REG_SPARE_HI, 5'($urandom_range(0, 31)));
    cfg_valid = 1'b0;
    send_sample(16'd255);

    // Random phases: new setting each phase, samples mostly within the
    // source depth, some corners and some arbitrary 16-bit words.
    phase = 0;
    while (sent_count < TOTAL_ITEMS) begin
      apply_setting(rand_depth(), rand_depth(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      no_idle = (phase % 4 == 2);
      if (phase == 3) hold_request = 1'b1;
      count = $urandom_range(40, 90);
      lim   = board.depth_full_scale();
      repeat (count) begin
        case ($urandom_range(0, 9))
          0:       x = 16'($urandom_range(0, 65535));
          1:       x = $urandom_range(0, 1) ? 16'(lim) : 16'd0;
          default: x = 16'($urandom_range(0, lim));
        endcase
        send_sample(x);
      end
      phase++;
    end

    in_valid = 1'b0;
    no_idle  = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d samples over %0d register settings: shift, pass and scaled modes,",
             board.checked, setting_count);
    $display("depth clamping, out-of-range samples and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
